// ===== rtl/binary_heap_priority_queue_defines.svh =====
// Assertion macros for the binary heap priority queue.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BHPQ_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bhpq check failed");

`define BHPQ_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bhpq check failed");

`else

`define BHPQ_ASSERT_SAME(name, ante, cons)

`define BHPQ_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/bhpq_pkg.sv =====
// Shared types, codes and helpers for the binary heap priority queue.
package bhpq_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int KEY_W        = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   localparam key_type KEY_NONE = '1;

   typedef enum logic {
      FN_INSERT = 1'b0,
      FN_SERVE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      func_type func;
      key_type  key_in;
   } req_type;

   typedef struct packed {
      status_type status;
      key_type    top_key;
      logic       top_valid;
      logic [6:0] entry_count;
      logic       is_full;
   } rsp_type;

   // true when key a must stand above key b
   function automatic logic ahead(key_type a, key_type b, logic mode);
      return mode ? (a > b) : (a < b);
   endfunction

endpackage

// ===== rtl/bhpq_ram.sv =====
// Heap key store: one write port, two registered read ports.
module bhpq_ram
   import bhpq_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  key_type       wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output key_type       rd_data_a,
   output key_type       rd_data_b
);

   key_type mem [DEPTH];
   key_type rd_a_ff;
   key_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue top level. Busy is low in the response cycle: one request at a time.
// Rejected requests, inserts into an empty heap and serves of the last key respond in the cycle after the request.
// Insert: sift-up one level at a time in S_UP, then the final write of the new key.
// Serve: one read of the last key in S_DN_LAST, then sift-down one level at a time in S_DN_CMP.
// The key store has a single write port; each response strobes for one cycle.
// Reset clears count, order mode and control; the key store is not cleared.
`include "binary_heap_priority_queue_defines.svh"

module binary_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CHW = IW + 2;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_UP      = 5'b00010,
      S_DN_LAST = 5'b00100,
      S_DN_CMP  = 5'b01000,
      S_FIN     = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    idx_ff, idx_in;
   key_type          key_ff, key_in;
   key_type          root_ff, root_in;
   logic             mode_ff, mode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   status_type       status_in;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   key_type          wr_data;
   logic [IW-1:0]    rd_addr_a;
   logic [IW-1:0]    rd_addr_b;
   key_type          rd_data_a;
   key_type          rd_data_b;

   logic [CHW-1:0]   left_idx;
   logic [CHW-1:0]   right_idx;
   logic [CHW-1:0]   best_idx;
   logic [CHW-1:0]   next_left;
   logic [CHW-1:0]   count_ext;
   key_type          best_key;
   logic [IW-1:0]    parent_idx;
   logic [IW-1:0]    parent_cnt;
   logic [IW-1:0]    parent_par;

   function automatic logic [IW-1:0] parent_of(logic [IW-1:0] i);
      return IW'((i - IW'(1)) >> 1);
   endfunction

   bhpq_ram #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign busy = (state_ff != S_IDLE);

   // child and parent indexes of the current hole
   always_comb begin
      count_ext  = CHW'(count_ff);
      left_idx   = {1'b0, idx_ff, 1'b1};
      right_idx  = left_idx + CHW'(1);
      if ((right_idx < count_ext) && ahead(rd_data_b, rd_data_a, mode_ff)) begin
         best_idx = right_idx;
         best_key = rd_data_b;
      end else begin
         best_idx = left_idx;
         best_key = rd_data_a;
      end
      next_left  = {best_idx[CHW-2:0], 1'b1};
      parent_idx = parent_of(idx_ff);
      parent_par = parent_of(parent_idx);
      parent_cnt = parent_of(count_ff[IW-1:0]);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      rsp_valid_in = 1'b0;
      status_in    = ST_DONE;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = key_ff;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.func == FN_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in    = ST_FULL;
                     rsp_valid_in = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                     if (count_ff == '0) begin
                        wr_en        = 1'b1;
                        wr_addr      = '0;
                        wr_data      = req_data.key_in;
                        rsp_valid_in = 1'b1;
                     end else begin
                        key_in    = req_data.key_in;
                        idx_in    = count_ff[IW-1:0];
                        rd_addr_a = parent_cnt;
                        state_in  = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in    = ST_EMPTY;
                     rsp_valid_in = 1'b1;
                  end else begin
                     count_in = count_ff - CW'(1);
                     if (count_ff == CW'(1)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        // fetch the last key, it moves to the root
                        rd_addr_a = IW'(count_ff - CW'(1));
                        idx_in    = '0;
                        state_in  = S_DN_LAST;
                     end
                  end
               end
            end
         end

         S_UP: begin
            if (ahead(key_ff, rd_data_a, mode_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data_a;
               idx_in  = parent_idx;
               if (parent_idx == '0) begin
                  state_in = S_FIN;
               end else begin
                  rd_addr_a = parent_par;
               end
            end else begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_DN_LAST: begin
            key_in = rd_data_a;
            if (left_idx >= count_ext) begin
               wr_en        = 1'b1;
               wr_data      = rd_data_a;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_addr_a = left_idx[IW-1:0];
               rd_addr_b = right_idx[IW-1:0];
               state_in  = S_DN_CMP;
            end
         end

         S_DN_CMP: begin
            if (ahead(best_key, key_ff, mode_ff)) begin
               wr_en   = 1'b1;
               wr_data = best_key;
               idx_in  = best_idx[IW-1:0];
               if (next_left >= count_ext) begin
                  state_in = S_FIN;
               end else begin
                  rd_addr_a = next_left[IW-1:0];
                  rd_addr_b = IW'(next_left + CHW'(1));
               end
            end else begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_FIN: begin
            wr_en        = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // track the root so the top key needs no extra read
   always_comb begin
      root_in = (wr_en && (wr_addr == '0)) ? wr_data : root_ff;
      rsp_in.status      = status_in;
      rsp_in.top_key     = (count_in != '0) ? root_in : KEY_NONE;
      rsp_in.top_valid   = (count_in != '0);
      rsp_in.entry_count = 7'(count_in);
      rsp_in.is_full     = (count_in == CW'(CAPACITY));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      key_ff  <= key_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BHPQ_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CW'(CAPACITY))
   `BHPQ_ASSERT_NEXT(a_start_progress, start && !busy, busy || rsp_valid)
   `BHPQ_ASSERT_SAME(a_top_valid_count, rsp_valid, rsp_data.top_valid == (count_ff != '0))
   `BHPQ_ASSERT_SAME(a_no_rsp_while_busy, busy && !$past(busy), !rsp_valid)

endmodule
